FILE: src/ptts_pkg.sv
// package: request codes, result kinds, entry types and defaults for the scheduler
package ptts_pkg;

    localparam int DEF_MAX_TASKS  = 8;
    localparam int DEF_MAX_TIMERS = 8;

    localparam int REQ_W   = 4;
    localparam int ID_W    = 4;
    localparam int TIME_W  = 16;
    localparam int STEP_W  = 10;
    localparam int ELAP_W  = 17;
    localparam int KIND_W  = 2;
    localparam int REM_W   = STEP_W + 1;

    localparam logic [STEP_W-1:0] STEP_RESET = 10'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK         = 4'd0,
        REQ_ADD_TASK     = 4'd1,
        REQ_STOP_TASK    = 4'd2,
        REQ_START_TASK   = 4'd3,
        REQ_SET_PERIOD   = 4'd4,
        REQ_ADD_TIMER    = 4'd5,
        REQ_READ_TIMER   = 4'd6,
        REQ_RELOAD_TIMER = 4'd7,
        REQ_START_TIMER  = 4'd8,
        REQ_STOP_TIMER   = 4'd9
    } t_req;

    typedef enum logic [KIND_W-1:0] {
        KIND_STATUS   = 2'd0,
        KIND_DISPATCH = 2'd1,
        KIND_EXPIRY   = 2'd2,
        KIND_DONE     = 2'd3
    } t_kind;

    typedef struct packed {
        logic              enabled;
        logic [ELAP_W-1:0] elapsed;
        logic [TIME_W-1:0] period;
    } t_task;

    typedef struct packed {
        logic              running;
        logic [TIME_W-1:0] reload;
        logic [TIME_W-1:0] remaining;
    } t_timer;

endpackage

FILE: src/ptts_if.sv
// interfaces: request channel and result channel
interface ptts_req_if;
    logic                          valid;
    logic                          ready;
    logic [ptts_pkg::REQ_W-1:0]    req_type;
    logic [ptts_pkg::ID_W-1:0]     item_id;
    logic [ptts_pkg::TIME_W-1:0]   time_value;

    modport source (output valid, req_type, item_id, time_value, input ready);
    modport sink   (input valid, req_type, item_id, time_value, output ready);
endinterface

interface ptts_res_if;
    logic                          valid;
    logic                          ready;
    logic [ptts_pkg::KIND_W-1:0]   result_kind;
    logic                          ok;
    logic [ptts_pkg::ID_W-1:0]     out_id;
    logic [ptts_pkg::TIME_W-1:0]   count_value;
    logic                          last;

    modport source (output valid, result_kind, ok, out_id, count_value, last, input ready);
    modport sink   (input valid, result_kind, ok, out_id, count_value, last, output ready);
endinterface

FILE: src/periodic_task_and_timer_scheduler.sv
// top level: periodic task and timer scheduler built from two rotating chains of entry cells
// a command runs a remainder check of its time value by the tick step, a walk over the task
// cells and then the timer cells, and a final status result; a tick skips the remainder check
// one item at a time; a full result register stalls the walk until it is taken
// reset is synchronous active low: tick step 1, both tables empty, no result pending
module periodic_task_and_timer_scheduler #(
    parameter int MAX_TASKS  = ptts_pkg::DEF_MAX_TASKS,
    parameter int MAX_TIMERS = ptts_pkg::DEF_MAX_TIMERS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ptts_pkg::STEP_W-1:0] i_cfg_data,
    ptts_req_if.sink                    i_req,
    ptts_res_if.source                  o_res
);
    import ptts_pkg::*;

    localparam int NMAX  = (MAX_TASKS > MAX_TIMERS) ? MAX_TASKS : MAX_TIMERS;
    localparam int CW    = (NMAX > 1) ? $clog2(NMAX) : 1;
    localparam int TOTW  = $clog2(NMAX + 1);
    localparam int TSK_W = $bits(t_task);
    localparam int TMR_W = $bits(t_timer);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MOD   = 5'b00010,
        S_TASK  = 5'b00100,
        S_TIMER = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step;
    logic [REQ_W-1:0]    r_req;
    logic [ID_W-1:0]     r_id;
    logic [TIME_W-1:0]   r_tv;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [3:0]          r_bit;
    logic [CW-1:0]       r_idx;
    logic [TOTW-1:0]     r_task_total, r_timer_total;
    logic [TIME_W-1:0]   r_cnt;
    logic                r_ovalid;
    logic [KIND_W-1:0]   r_okind;
    logic                r_ook;
    logic [ID_W-1:0]     r_oid;
    logic [TIME_W-1:0]   r_ocnt;
    logic                r_olast;

    logic [STEP_W-1:0]   step_eff;
    logic [REM_W-1:0]    rem_sh;
    logic                mult, is_tick, task_ok, tmr_ok, task_sel, tmr_sel;
    logic                out_free, emit, advance, last_idx, shift_task, shift_tmr;
    logic                task_add, tmr_add, task_reg, tmr_reg, due;
    logic [ELAP_W:0]     el_sum;
    logic [ELAP_W-1:0]   el0;
    t_task               task_head, task_new;
    t_timer              tmr_head, tmr_new;
    logic [KIND_W-1:0]   e_kind;
    logic                e_ok;
    logic [ID_W-1:0]     e_id;
    logic [TIME_W-1:0]   e_cnt;
    logic                e_last;
    logic [TSK_W-1:0]    task_link [MAX_TASKS+1];
    logic [TMR_W-1:0]    tmr_link  [MAX_TIMERS+1];

    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++) begin : g_task
            ptts_cell #(.W(TSK_W)) u_cell (
                .i_clk  (i_clk),
                .i_shift(shift_task),
                .i_data (task_link[g+1]),
                .o_data (task_link[g])
            );
        end
        for (g = 0; g < MAX_TIMERS; g++) begin : g_tmr
            ptts_cell #(.W(TMR_W)) u_cell (
                .i_clk  (i_clk),
                .i_shift(shift_tmr),
                .i_data (tmr_link[g+1]),
                .o_data (tmr_link[g])
            );
        end
    endgenerate

    assign task_link[MAX_TASKS] = task_new;
    assign tmr_link[MAX_TIMERS] = tmr_new;
    assign task_head = t_task'(task_link[0]);
    assign tmr_head  = t_timer'(tmr_link[0]);

    assign step_eff = (r_step == '0) ? STEP_W'(1) : r_step;
    assign rem_sh   = {r_rem[REM_W-2:0], r_tv[r_bit]};
    assign mult     = (r_rem == '0);
    assign is_tick  = (r_req == REQ_TICK);
    assign task_ok  = (r_id != '0) && (int'(r_id) <= int'(r_task_total));
    assign tmr_ok   = (r_id != '0) && (int'(r_id) <= int'(r_timer_total));
    assign task_sel = task_ok && (int'(r_idx) + 1 == int'(r_id));
    assign tmr_sel  = tmr_ok && (int'(r_idx) + 1 == int'(r_id));
    assign task_reg = int'(r_idx) < int'(r_task_total);
    assign tmr_reg  = int'(r_idx) < int'(r_timer_total);
    assign task_add = (int'(r_idx) == int'(r_task_total)) && (int'(r_task_total) < MAX_TASKS)
                      && mult;
    assign tmr_add  = (int'(r_idx) == int'(r_timer_total))
                      && (int'(r_timer_total) < MAX_TIMERS) && mult;
    assign out_free = !r_ovalid || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_rem = (rem_sh >= REM_W'(step_eff)) ? rem_sh - REM_W'(step_eff) : rem_sh;

        due    = task_head.elapsed >= ELAP_W'(task_head.period);
        el0    = due ? '0 : task_head.elapsed;
        el_sum = {1'b0, el0} + (ELAP_W+1)'(step_eff);

        task_new = task_head;
        if (is_tick && task_reg) begin
            task_new.elapsed = el_sum[ELAP_W] ? {ELAP_W{1'b1}} : el_sum[ELAP_W-1:0];
        end else if (r_req == REQ_ADD_TASK && task_add) begin
            task_new.enabled = 1'b1;
            task_new.elapsed = '0;
            task_new.period  = r_tv;
        end else if ((r_req == REQ_STOP_TASK || r_req == REQ_START_TASK) && task_sel) begin
            task_new.enabled = (r_req == REQ_START_TASK);
        end else if (r_req == REQ_SET_PERIOD && task_sel && mult) begin
            task_new.period = r_tv;
        end

        tmr_new = tmr_head;
        if (is_tick && tmr_reg) begin
            if (tmr_head.running) begin
                tmr_new.remaining = (tmr_head.remaining >= TIME_W'(step_eff))
                                    ? tmr_head.remaining - TIME_W'(step_eff) : '0;
            end
        end else if (r_req == REQ_ADD_TIMER && tmr_add) begin
            tmr_new.running   = 1'b0;
            tmr_new.reload    = r_tv;
            tmr_new.remaining = r_tv;
        end else if (r_req == REQ_RELOAD_TIMER && tmr_sel && mult) begin
            tmr_new.running   = 1'b1;
            tmr_new.reload    = r_tv;
            tmr_new.remaining = r_tv;
        end else if (r_req == REQ_START_TIMER && tmr_sel) begin
            tmr_new.running = 1'b1;
            if (tmr_head.remaining == '0) begin
                tmr_new.remaining = tmr_head.reload;
            end
        end else if (r_req == REQ_STOP_TIMER && tmr_sel) begin
            tmr_new.running = 1'b0;
        end

        e_kind = KIND_STATUS;
        e_ok   = 1'b1;
        e_id   = ID_W'(r_idx) + ID_W'(1);
        e_cnt  = '0;
        e_last = 1'b0;
        emit   = 1'b0;
        case (r_state)
            S_TASK: begin
                e_kind = KIND_DISPATCH;
                emit   = is_tick && task_reg && due && task_head.enabled;
            end
            S_TIMER: begin
                e_kind = KIND_EXPIRY;
                emit   = is_tick && tmr_reg && (tmr_head.remaining == '0);
            end
            S_FIN: begin
                emit   = 1'b1;
                e_last = 1'b1;
                e_id   = '0;
                case (r_req)
                    REQ_TICK: begin
                        e_kind = KIND_DONE;
                    end
                    REQ_ADD_TASK: begin
                        e_ok = (int'(r_task_total) < MAX_TASKS) && mult;
                        e_id = e_ok ? ID_W'(r_task_total) + ID_W'(1) : '0;
                    end
                    REQ_STOP_TASK, REQ_START_TASK: e_ok = task_ok;
                    REQ_SET_PERIOD:                e_ok = task_ok && mult;
                    REQ_ADD_TIMER: begin
                        e_ok = (int'(r_timer_total) < MAX_TIMERS) && mult;
                        e_id = e_ok ? ID_W'(r_timer_total) + ID_W'(1) : '0;
                    end
                    REQ_READ_TIMER: begin
                        e_ok  = tmr_ok;
                        e_cnt = tmr_ok ? r_cnt : '0;
                    end
                    REQ_RELOAD_TIMER:               e_ok = tmr_ok && mult;
                    REQ_START_TIMER, REQ_STOP_TIMER: e_ok = tmr_ok;
                    default:                        e_ok = 1'b0;
                endcase
            end
            default: emit = 1'b0;
        endcase
        advance = !emit || out_free;

        last_idx = 1'b0;
        case (r_state)
            S_TASK:  last_idx = (int'(r_idx) == MAX_TASKS - 1);
            S_TIMER: last_idx = (int'(r_idx) == MAX_TIMERS - 1);
            default: last_idx = 1'b0;
        endcase
        shift_task = (r_state == S_TASK) && advance;
        shift_tmr  = (r_state == S_TIMER) && advance;

        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = (i_req.req_type == REQ_TICK) ? S_TASK : S_MOD;
                end
            end
            S_MOD:   if (r_bit == '0) n_state = S_TASK;
            S_TASK:  if (advance && last_idx) n_state = S_TIMER;
            S_TIMER: if (advance && last_idx) n_state = S_FIN;
            S_FIN:   if (advance) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_step        <= STEP_RESET;
            r_task_total  <= '0;
            r_timer_total <= '0;
            r_ovalid      <= 1'b0;
            r_idx         <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_step <= i_cfg_data;
            end
            if ((shift_task || shift_tmr) && !last_idx) begin
                r_idx <= r_idx + CW'(1);
            end else if (shift_task || shift_tmr) begin
                r_idx <= '0;
            end
            if (r_state == S_FIN && advance) begin
                if (r_req == REQ_ADD_TASK && e_ok) begin
                    r_task_total <= r_task_total + TOTW'(1);
                end
                if (r_req == REQ_ADD_TIMER && e_ok) begin
                    r_timer_total <= r_timer_total + TOTW'(1);
                end
            end
            if (emit && advance) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_req <= i_req.req_type;
            r_id  <= i_req.item_id;
            r_tv  <= i_req.time_value;
            r_rem <= '0;
            r_bit <= 4'd15;
            r_cnt <= '0;
        end
        if (r_state == S_MOD) begin
            r_rem <= n_rem;
            r_bit <= r_bit - 4'd1;
        end
        if (r_state == S_TIMER && r_req == REQ_READ_TIMER && tmr_sel) begin
            r_cnt <= tmr_head.remaining;
        end
        if (emit && advance) begin
            r_okind <= e_kind;
            r_ook   <= e_ok;
            r_oid   <= e_id;
            r_ocnt  <= e_cnt;
            r_olast <= e_last;
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.result_kind = r_okind;
    assign o_res.ok          = r_ook;
    assign o_res.out_id      = r_oid;
    assign o_res.count_value = r_ocnt;
    assign o_res.last        = r_olast;
endmodule

FILE: src/ptts_cell.sv
// one entry cell of a rotating table chain
module ptts_cell #(
    parameter int W = 34
) (
    input  logic         i_clk,
    input  logic         i_shift,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;
endmodule

FILE: src/ptts_chk.sv
// checker: port level properties of the scheduler, bound to the top level
module ptts_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [ptts_pkg::KIND_W-1:0] i_kind,
    input logic [ptts_pkg::ID_W-1:0]   i_id,
    input logic [ptts_pkg::TIME_W-1:0] i_cnt,
    input logic                        i_last
);
    import ptts_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) && $stable(i_id)
            && $stable(i_last))
        else $error("stalled result changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second transfer taken while busy");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last |-> i_kind == KIND_STATUS || i_kind == KIND_DONE)
        else $error("last flag on dispatch or expiry");

    a_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_DISPATCH || i_kind == KIND_EXPIRY)
            |-> !i_last && i_id != '0 && i_cnt == '0)
        else $error("bad dispatch or expiry result");
endmodule

bind periodic_task_and_timer_scheduler ptts_chk u_ptts_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_req.valid),
    .i_in_ready (i_req.ready),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_kind     (o_res.result_kind),
    .i_id       (o_res.out_id),
    .i_cnt      (o_res.count_value),
    .i_last     (o_res.last)
);
